/* hw/rtl/skls_pkg.sv */
// Package for the sparse key leaf store.
// Holds request/result payload types, action and status codes, FSM states
// and default sizes. No dependencies.
package skls_pkg;

  localparam int SKLS_CAPACITY        = 1024;
  localparam int SKLS_ENTRIES_PER_KEY = 16;
  localparam int SKLS_KEY_SLOTS       = 64;

  typedef enum logic [2:0] {
    ACT_CLEAR    = 3'd0,
    ACT_APPEND   = 3'd1,
    ACT_SEARCH   = 3'd2,
    ACT_READ_ID  = 3'd3,
    ACT_READ_KEY = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2
  } sts_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_RD_ID  = 5'b00100,
    ST_RD_KEY = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [30:0]        object_id;
    logic signed [31:0] key_value;
    logic [9:0]         slot_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [5:0]         position;
    logic signed [31:0] read_id;
    logic signed [31:0] read_key;
    logic [10:0]        entry_count;
    logic [6:0]         key_count;
    logic               is_full;
  } out_t;

endpackage

/* hw/rtl/skls_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module skls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/sparse_key_leaf_store.sv */
// Sparse key leaf store top level: id and key memories plus the request FSM.
// Depends on skls_pkg and skls_ram.
//
//   channel | ports                           | payload
//   --------+---------------------------------+---------
//   request | in_valid  in_stall  in_data     | in_t
//   result  | out_valid out_stall out_data    | out_t
//
// One request at a time. Clear, append, unused actions, out-of-range reads
// and a search of an empty leaf go through FIN to the output register;
// reads of an id or key pass RD_ID or RD_KEY first for the registered RAM
// read. Any other search scans the key RAM read port one slot per cycle from
// the newest key down, then goes to FIN; a hit ends the scan early.
// Reset (rst_n, synchronous, active low) clears both counts; the memories are
// not cleared and need no sweep. The output register lets the next request
// enter while a result waits under out_stall; a finished result waits in FIN.
module sparse_key_leaf_store
  import skls_pkg::*;
#(
  parameter int CAPACITY        = SKLS_CAPACITY,
  parameter int ENTRIES_PER_KEY = SKLS_ENTRIES_PER_KEY,
  parameter int KEY_SLOTS       = SKLS_KEY_SLOTS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // counter, address and compare widths
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int XW  = (CW > 10) ? CW : 10;
  localparam int KCW = $clog2(KEY_SLOTS + 1);
  localparam int KAW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int XKW = (KCW > 10) ? KCW : 10;
  localparam int PW  = (ENTRIES_PER_KEY > 1) ? $clog2(ENTRIES_PER_KEY) : 1;
  localparam int ECW = (CW > 11) ? CW : 11;
  localparam int KXW = (KCW > 7) ? KCW : 7;
  localparam int PXW = (KAW > 6) ? KAW : 6;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      ent_cnt_r, ent_cnt_nxt;
  logic [KCW-1:0]     key_cnt_r, key_cnt_nxt;
  logic [PW-1:0]      ph_r, ph_nxt;     // entries_held mod ENTRIES_PER_KEY
  logic signed [31:0] query_r, query_nxt;
  logic [KCW-1:0]     scan_r, scan_nxt; // key slots not yet issued
  logic [KAW-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  out_t               res_r, res_nxt;
  out_t               out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic               id_we, key_we;
  logic [AW-1:0]      id_waddr, id_raddr;
  logic [30:0]        id_rdata;
  logic [KAW-1:0]     key_waddr, key_raddr, scan_addr, key_idx_addr;
  logic [31:0]        key_rdata;

  logic [XW-1:0]      idx_x, ent_x;
  logic [XKW-1:0]     kidx_x, kcnt_x;
  logic [KCW-1:0]     scan_m1;
  logic [ECW-1:0]     ent_ox;
  logic [KXW-1:0]     key_ox;
  logic [PXW-1:0]     pos_x;
  logic               need_key, ent_full, key_full, rd_id_ok, rd_key_ok, hit;

  assign idx_x     = XW'(in_data.slot_index);
  assign ent_x     = XW'(ent_cnt_r);
  assign kidx_x    = XKW'(in_data.slot_index);
  assign kcnt_x    = XKW'(key_cnt_r);
  assign rd_id_ok  = (idx_x < ent_x) && (idx_x < XW'(CAPACITY));
  assign rd_key_ok = (kidx_x < kcnt_x) && (kidx_x < XKW'(KEY_SLOTS));
  assign need_key  = (ph_r == '0);
  assign ent_full  = (ent_cnt_r >= CW'(CAPACITY));
  assign key_full  = (key_cnt_r >= KCW'(KEY_SLOTS));

  assign id_waddr     = ent_cnt_r[AW-1:0];
  assign id_raddr     = idx_x[AW-1:0];
  assign key_waddr    = key_cnt_r[KAW-1:0];
  assign key_idx_addr = kidx_x[KAW-1:0];
  assign scan_m1      = scan_r - 1'b1;
  assign scan_addr    = scan_m1[KAW-1:0];
  assign key_raddr    = (state_r == ST_SCAN) ? scan_addr : key_idx_addr;

  // signed Q16.16 compare of the key under test against the query
  assign hit = ($signed(key_rdata) <= query_r);

  assign ent_ox = ECW'(ent_cnt_r);
  assign key_ox = KXW'(key_cnt_r);
  assign pos_x  = PXW'(cmp_idx_r);

  skls_ram #(
    .WIDTH (31),
    .DEPTH (CAPACITY)
  ) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (in_data.object_id),
    .raddr (id_raddr),
    .rdata (id_rdata)
  );

  skls_ram #(
    .WIDTH (32),
    .DEPTH (KEY_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_data.key_value),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    ent_cnt_nxt   = ent_cnt_r;
    key_cnt_nxt   = key_cnt_r;
    ph_nxt        = ph_r;
    query_nxt     = query_r;
    scan_nxt      = scan_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_vld_nxt   = cmp_vld_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    id_we         = 1'b0;
    key_we        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          query_nxt = in_data.key_value;
          state_nxt = ST_FIN;
          case (in_data.action)
            ACT_CLEAR: begin
              ent_cnt_nxt = '0;
              key_cnt_nxt = '0;
              ph_nxt      = '0;
            end
            ACT_APPEND: begin
              if (ent_full || (need_key && key_full)) begin
                res_nxt.status = STS_FULL;
              end else begin
                id_we       = 1'b1;
                ent_cnt_nxt = ent_cnt_r + 1'b1;
                ph_nxt      = (ph_r == PW'(ENTRIES_PER_KEY - 1)) ? '0 : ph_r + 1'b1;
                if (need_key) begin
                  key_we      = 1'b1;
                  key_cnt_nxt = key_cnt_r + 1'b1;
                end
              end
            end
            ACT_SEARCH: begin
              // no keys: not found, straight to the result
              if (key_cnt_r != '0) begin
                scan_nxt    = key_cnt_r;
                cmp_vld_nxt = 1'b0;
                state_nxt   = ST_SCAN;
              end
            end
            ACT_READ_ID: begin
              if (rd_id_ok) begin
                state_nxt = ST_RD_ID;
              end else begin
                res_nxt.status = STS_RANGE;
              end
            end
            ACT_READ_KEY: begin
              if (rd_key_ok) begin
                state_nxt = ST_RD_KEY;
              end else begin
                res_nxt.status = STS_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // issue one slot per cycle, compare the slot issued last cycle
        if (cmp_vld_r && hit) begin
          res_nxt.found    = 1'b1;
          res_nxt.position = pos_x[5:0];
          cmp_vld_nxt      = 1'b0;
          state_nxt        = ST_FIN;
        end else if (scan_r != '0) begin
          scan_nxt    = scan_m1;
          cmp_idx_nxt = scan_addr;
          cmp_vld_nxt = 1'b1;
        end else begin
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_FIN;
        end
      end
      ST_RD_ID: begin
        res_nxt.read_id = $signed({1'b0, id_rdata});
        state_nxt       = ST_FIN;
      end
      ST_RD_KEY: begin
        res_nxt.read_key = $signed(key_rdata);
        state_nxt        = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt             = res_r;
          out_data_nxt.entry_count = ent_ox[10:0];
          out_data_nxt.key_count   = key_ox[6:0];
          out_data_nxt.is_full     = ent_full;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ent_cnt_r   <= '0;
      key_cnt_r   <= '0;
      ph_r        <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ent_cnt_r   <= ent_cnt_nxt;
      key_cnt_r   <= key_cnt_nxt;
      ph_r        <= ph_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    query_r    <= query_nxt;
    scan_r     <= scan_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // an accepted request always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != ST_IDLE))
    else $error("accepted request did not leave idle");

  a_ent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ent_cnt_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_key_bound: assert property (@(posedge clk) disable iff (!rst_n)
    key_cnt_r <= KCW'(KEY_SLOTS))
    else $error("key count beyond key slots");

  // a search hit never carries an error status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.found) |-> (out_data_r.status == STS_OK))
    else $error("found result with error status");

endmodule

/* test/skls_result_checker.sv */
// Result checker for the sparse key leaf store: keeps its own copy of the
// leaf contents, predicts one result per accepted request and compares them.
// Depends on skls_pkg.
module skls_result_checker
  import skls_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   mismatches,
  output int   pending
);

  logic [31:0] id_mem  [SKLS_CAPACITY];
  logic [31:0] key_mem [SKLS_KEY_SLOTS];
  int          entries_held;
  int          keys_held;
  out_t        results_due [$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    entries_held = 0;
    keys_held    = 0;
  end

  // Applies one request to the leaf copy and returns the result it gives.
  function automatic out_t leaf_apply(input in_t req);
    out_t res;
    logic need_key;
    int   i;
    res = '0;
    case (req.action)
      ACT_CLEAR: begin
        entries_held = 0;
        keys_held    = 0;
      end
      ACT_APPEND: begin
        need_key = (entries_held % SKLS_ENTRIES_PER_KEY) == 0;
        if (entries_held >= SKLS_CAPACITY || (need_key && keys_held >= SKLS_KEY_SLOTS)) begin
          res.status = STS_FULL;
        end else begin
          id_mem[entries_held] = {1'b0, req.object_id};
          if (need_key) begin
            key_mem[keys_held] = req.key_value;
            keys_held++;
          end
          entries_held++;
        end
      end
      ACT_SEARCH: begin
        // newest key first; first one not above the query wins
        for (i = keys_held - 1; i >= 0; i--) begin
          if (!res.found && $signed(key_mem[i]) <= $signed(req.key_value)) begin
            res.found    = 1'b1;
            res.position = i[5:0];
          end
        end
      end
      ACT_READ_ID: begin
        if (req.slot_index < entries_held) res.read_id = id_mem[req.slot_index];
        else res.status = STS_RANGE;
      end
      ACT_READ_KEY: begin
        if (req.slot_index < keys_held) res.read_key = key_mem[req.slot_index];
        else res.status = STS_RANGE;
      end
      default: ;
    endcase
    res.entry_count = entries_held[10:0];
    res.key_count   = keys_held[6:0];
    res.is_full     = entries_held >= SKLS_CAPACITY;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 200) $display("%0t: mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      entries_held = 0;
      keys_held    = 0;
      results_due.delete();
    end else begin
      // compare first: a result never belongs to a request taken at this edge
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = results_due.pop_front();
          check_field("status",      out_data.status,      want.status);
          check_field("found",       out_data.found,       want.found);
          check_field("position",    out_data.position,    want.position);
          check_field("read_id",     out_data.read_id,     want.read_id);
          check_field("read_key",    out_data.read_key,    want.read_key);
          check_field("entry_count", out_data.entry_count, want.entry_count);
          check_field("key_count",   out_data.key_count,   want.key_count);
          check_field("is_full",     out_data.is_full,     want.is_full);
        end
      end
      if (in_valid && !in_stall) results_due.push_back(leaf_apply(in_data));
    end
    pending <= results_due.size();
  end

endmodule

/* test/tb_sparse_key_leaf_store.sv */
// Testbench top for the sparse key leaf store: clock, reset, request and
// result drivers, watchdog and verdict. Depends on skls_pkg, the block and
// skls_result_checker.
module tb_sparse_key_leaf_store;
  import skls_pkg::*;

  // Action codes the block ignores.
  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

  localparam logic [31:0] KEY_MIN = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX = 32'h7fff_ffff;

  localparam int TOTAL_REQS   = 525;  // directed part plus about 500 random
  localparam int HOLD_AT      = 150;  // where the receiver starts its long hold
  localparam int HOLD_CYCLES  = 250;
  localparam int CALM_FROM    = 330;  // no idling on either side in this window
  localparam int CALM_TO      = 450;
  localparam int DRAIN_CYCLES = 80;   // longer than a full-depth search
  // Longest correct quiet spell: a 64-key search behind the long
  // hold; taken several times over.
  localparam int QUIET_LIMIT  = 2000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int mismatches;
  int pending;
  int accepted_reqs = 0;
  int issued        = 0;

  // Sender-side view of the fill level, used only to aim reads and queries
  // at live entries.
  int          held = 0;
  logic [31:0] key_hist [SKLS_KEY_SLOTS];
  logic [31:0] last_key = '0;

  wire calm = accepted_reqs >= CALM_FROM && accepted_reqs < CALM_TO;

  initial begin
    forever #2 clk = ~clk;
  end

  sparse_key_leaf_store i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  skls_result_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  // Request counter updated with NBAs so every process sees the value at
  // the edge, whatever order they run in.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) accepted_reqs <= accepted_reqs + 1;
  end

  function automatic in_t compose_request(input logic [2:0] act, input logic [30:0] id,
                                          input logic [31:0] key, input logic [9:0] idx);
    in_t req;
    req.action     = act;
    req.object_id  = id;
    req.key_value  = key;
    req.slot_index = idx;
    return req;
  endfunction

  function automatic int shadow_keys();
    return (held + SKLS_ENTRIES_PER_KEY - 1) / SKLS_ENTRIES_PER_KEY;
  endfunction

  // Keys mostly climb, as they do in a sorted leaf, with random jumps mixed in.
  function automatic logic [31:0] next_append_key();
    if ($urandom_range(99) < 70) last_key = last_key + $urandom_range(1 << 20, 1);
    else last_key = $urandom;
    return last_key;
  endfunction

  // Queries land on, just below or just above a stored key most of the time,
  // so the scan stops at varied slots.
  function automatic logic [31:0] pick_query();
    int kc;
    int r;
    kc = shadow_keys();
    r  = $urandom_range(99);
    if (kc > 0 && r < 55) return key_hist[$urandom_range(kc - 1)] + $urandom_range(2) - 1;
    if (r < 70) return r[0] ? KEY_MIN : KEY_MAX;
    return $urandom;
  endfunction

  // Mostly a live index; otherwise anything the field holds.
  function automatic logic [9:0] pick_slot(input int bound);
    logic [9:0] any_slot;
    any_slot = $urandom;
    if (bound > 0 && $urandom_range(99) < 85) return $urandom_range(bound - 1);
    return any_slot;
  endfunction

  function automatic in_t append_request();
    return compose_request(ACT_APPEND, $urandom, next_append_key(), $urandom);
  endfunction

  // Offers one request, possibly after a short idle gap, and returns at the
  // edge that takes it. Valid stays high afterwards for a back-to-back
  // request; the next call or the caller lowers it.
  task automatic issue(input in_t req);
    int gap;
    if (!calm && $urandom_range(99) < 18) begin
      gap = $urandom_range(4, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    issued++;
    if (req.action == ACT_CLEAR) begin
      held = 0;
    end else if (req.action == ACT_APPEND && held < SKLS_CAPACITY) begin
      if (held % SKLS_ENTRIES_PER_KEY == 0) key_hist[held / SKLS_ENTRIES_PER_KEY] = req.key_value;
      held++;
    end
  endtask

  task automatic random_request();
    int         r;
    int         n;
    logic [2:0] spare;
    logic [9:0] any_slot;
    r        = $urandom_range(99);
    spare    = $urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST);
    any_slot = $urandom;
    if (r < 40) begin
      // an occasional burst builds up several keys for the scan
      n = ($urandom_range(99) < 6) ? $urandom_range(64, 16) : 1;
      repeat (n) issue(append_request());
    end else if (r < 60) begin
      issue(compose_request(ACT_SEARCH, $urandom, pick_query(), $urandom));
    end else if (r < 72) begin
      issue(compose_request(ACT_READ_ID, $urandom, $urandom, pick_slot(held)));
    end else if (r < 82) begin
      issue(compose_request(ACT_READ_KEY, $urandom, $urandom, pick_slot(shadow_keys())));
    end else if (r < 84) begin
      issue(compose_request(ACT_CLEAR, $urandom, $urandom, $urandom));
    end else if (r < 88) begin
      issue(compose_request(ACT_READ_ID, $urandom, $urandom, any_slot));
    end else if (r < 92) begin
      issue(compose_request(ACT_READ_KEY, $urandom, $urandom, any_slot));
    end else begin
      issue(compose_request(spare, $urandom, $urandom, $urandom));
    end
  endtask

  // Result side: random stalls, one long hold while the sender keeps
  // offering (fills the output register and backs up the input), and a
  // window with no stalls at all.
  initial begin : result_receiver
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && accepted_reqs >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 18);
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : request_driver
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty leaf, field extremes, every action, unused codes.
    issue(compose_request(ACT_SEARCH,   '0, '0, '0));        // empty: nothing found
    issue(compose_request(ACT_READ_ID,  '0, '0, '0));        // out of range on empty
    issue(compose_request(ACT_READ_KEY, '0, '0, '0));
    issue(compose_request(ACT_APPEND,   '0, KEY_MIN, '0));   // entry 0 takes a key
    issue(compose_request(ACT_APPEND,   '1, KEY_MAX, '1));   // entry 1 takes none
    issue(compose_request(ACT_READ_ID,  '0, '0, 10'd1));
    issue(compose_request(ACT_READ_ID,  '1, '1, '0));
    issue(compose_request(ACT_READ_KEY, '0, '0, '0));
    issue(compose_request(ACT_READ_ID,  '0, '0, 10'd2));     // just past the count
    issue(compose_request(ACT_READ_KEY, '0, '0, 10'd1));
    issue(compose_request(ACT_SEARCH,   '0, KEY_MIN, '0));   // equal to the only key
    issue(compose_request(ACT_SEARCH,   '0, KEY_MAX, '0));
    issue(compose_request(ACT_READ_ID,  '0, '0, '1));
    issue(compose_request(ACT_READ_KEY, '0, '0, '1));
    issue(compose_request(ACT_UNUSED_FIRST, '1, '1, '1));
    issue(compose_request(ACT_UNUSED_FIRST + 3'd1, '0, '0, '0));
    issue(compose_request(ACT_UNUSED_LAST,  '1, '1, '1));
    issue(compose_request(ACT_CLEAR,    '1, '1, '1));
    issue(compose_request(ACT_READ_ID,  '0, '0, '0));        // cleared entries unreachable
    issue(compose_request(ACT_SEARCH,   '0, KEY_MAX, '0));
    issue(compose_request(ACT_APPEND,   31'h2aaa_aaaa, KEY_MAX, '0));
    issue(compose_request(ACT_SEARCH,   '0, KEY_MAX - 32'd1, '0));  // just below: miss
    issue(compose_request(ACT_SEARCH,   '0, KEY_MAX, '0));          // equal: hit
    issue(compose_request(ACT_READ_KEY, '0, '0, '0));

    // Sender pause: let every result come back before random traffic.
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);

    while (issued < TOTAL_REQS) random_request();

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
